// ----- hdl/flrt_pkg.sv -----
`timescale 1ns / 1ps

package flrt_pkg;

  // Fill-level band, ordered from an empty FIFO to a full one
  typedef enum logic [2:0] {
    BandVeryLow  = 3'd0,
    BandLow      = 3'd1,
    BandInRange  = 3'd2,
    BandHigh     = 3'd3,
    BandVeryHigh = 3'd4
  } band_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgBufferSize = 2'd0,
    CfgBlockRecip = 2'd1,
    CfgSpare2     = 2'd2,
    CfgSpare3     = 2'd3
  } cfg_idx_e;

  localparam int RatioW = 24;
  localparam int LambdaW = 13;

  // Smoothing weights, Q0.16
  localparam logic [LambdaW-1:0] LambdaFast = 13'd6554;
  localparam logic [LambdaW-1:0] LambdaSlow = 13'd655;

  // floor(x / 5) = (x * Div5Mult) >> Div5Shift, exact for any 24-bit x
  localparam int Div5Shift = 27;
  localparam logic [24:0] Div5Mult = 25'd26843546;
  localparam int Div5QuotW = 22;

  localparam logic [RatioW-1:0] RatioMax = 24'hFFFFFF;
  localparam logic [RatioW-1:0] BlockRecipReset = 24'd38044;

endpackage

// ----- hdl/fill_level_ratio_tracker.sv -----
`timescale 1ns / 1ps

// From the input transfer to out_valid_o an item passes the input register,
// correction product stage, clamp/target stage, then the smoothing update
// that writes the kept ratio straight into the output register.
// Throughput: one item per cycle unless out_ready_i stalls the output; the
// kept-ratio update is a single multiply-add loop closed within the output stage.
// Reset: all stages empty, kept ratio 0, buffer_size 88200, block_reciprocal 38044.
module fill_level_ratio_tracker #(
  parameter int FILL_WIDTH = 19
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [23:0]           cfg_data_i,

  // update ticks
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FILL_WIDTH-1:0] fill_level_i,
  input  logic [23:0]           nominal_ratio_i,
  input  logic                  restart_i,

  // updated ratio
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [23:0]           ratio_o,
  output logic [2:0]            band_o
);

  // d = buffer_size - 2*fill, signed, in half frames
  localparam int DW  = FILL_WIDTH + 2;
  // d * block_reciprocal
  localparam int PW  = DW + 25;
  // correction in Q8.16 after dropping 9 fraction bits
  localparam int CW  = PW - 9;
  // estimate = nominal + correction
  localparam int EW  = ((CW > 25) ? CW : 25) + 1;
  // band compares: up to 25 * fill
  localparam int BW  = FILL_WIDTH + 5;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are to be made only while the block is idle;
  // the block itself does not enforce this, and the pipeline reads them directly.
  // ---------------------------------------------------------------------
  logic [FILL_WIDTH-1:0] buf_size_q;
  logic [23:0]           recip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= FILL_WIDTH'(88200);
      recip_q    <= flrt_pkg::BlockRecipReset;
    end else if (cfg_valid_i) begin
      unique case (flrt_pkg::cfg_idx_e'(cfg_index_i))
        flrt_pkg::CfgBufferSize: buf_size_q <= cfg_data_i[FILL_WIDTH-1:0];
        flrt_pkg::CfgBlockRecip: recip_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage enables. Each stage loads when it is empty or its content moves
  // on, so bubbles collapse and an input transfer can happen while a
  // finished result is still waiting at the output.
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;

  assign en_o       = !vo_q || out_ready_i;
  assign en3        = !v3_q || en_o;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------
  logic [FILL_WIDTH-1:0] fill1_q;
  logic [23:0]           nom1_q;
  logic                  rst1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      fill1_q <= fill_level_i;
      nom1_q  <= nominal_ratio_i;
      rst1_q  <= restart_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: band classification, correction product, nominal / 5
  // ---------------------------------------------------------------------
  logic [BW-1:0]         fill_x, buf_x;
  logic                  lt40, lt48, gt60, gt52;
  flrt_pkg::band_e       band2_d;
  logic signed [DW-1:0]  diff_d;
  logic signed [PW-1:0]  prod_d;
  logic [48:0]           q5_prod;

  always_comb begin
    fill_x = BW'(fill1_q);
    buf_x  = BW'(buf_size_q);
    // exact percentage compares against buffer_size
    lt40 = (fill_x * BW'(5))  < (buf_x * BW'(2));
    lt48 = (fill_x * BW'(25)) < (buf_x * BW'(12));
    gt60 = (fill_x * BW'(5))  > (buf_x * BW'(3));
    gt52 = (fill_x * BW'(25)) > (buf_x * BW'(13));
    // very high is tested before high so both upper bands are reachable
    priority if (lt40) band2_d = flrt_pkg::BandVeryLow;
    else if (lt48)     band2_d = flrt_pkg::BandLow;
    else if (gt60)     band2_d = flrt_pkg::BandVeryHigh;
    else if (gt52)     band2_d = flrt_pkg::BandHigh;
    else               band2_d = flrt_pkg::BandInRange;

    diff_d  = $signed({2'b00, buf_size_q}) - $signed({1'b0, fill1_q, 1'b0});
    prod_d  = diff_d * $signed({1'b0, recip_q});
    q5_prod = nom1_q * flrt_pkg::Div5Mult;
  end

  logic signed [PW-1:0]                 prod2_q;
  logic [flrt_pkg::Div5QuotW-1:0]       q5_2_q;
  logic [23:0]                          nom2_q;
  logic                                 rst2_q;
  flrt_pkg::band_e                      band2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod2_q <= prod_d;
      q5_2_q  <= q5_prod[flrt_pkg::Div5Shift +: flrt_pkg::Div5QuotW];
      nom2_q  <= nom1_q;
      rst2_q  <= rst1_q;
      band2_q <= band2_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: estimate, clamp to [0.8, 1.2] x nominal, pick target/weight
  //   hi = floor(6n/5) = n + floor(n/5)
  //   lo = floor(4n/5) = n - ceil(n/5)
  // ---------------------------------------------------------------------
  logic signed [CW-1:0]  corr;
  logic signed [EW-1:0]  est;
  logic                  rem_nz;
  logic [24:0]           hi_b, lo_b;
  logic [24:0]           target_d;
  logic                  fast_d;

  always_comb begin
    // arithmetic shift floors, which matches rounding toward minus infinity
    corr   = $signed(prod2_q[PW-1:9]);
    est    = EW'(corr) + EW'($signed({1'b0, nom2_q}));
    rem_nz = nom2_q != (24'(q5_2_q) * 24'd5);
    hi_b   = 25'(nom2_q) + 25'(q5_2_q);
    lo_b   = 25'(nom2_q) - 25'(q5_2_q) - 25'(rem_nz);

    if (est > $signed(EW'(hi_b))) begin
      target_d = hi_b;
    end else if (est < $signed(EW'(lo_b))) begin
      target_d = lo_b;
    end else begin
      target_d = est[24:0];
    end
    fast_d = (band2_q != flrt_pkg::BandLow) && (band2_q != flrt_pkg::BandHigh);

    // in range: pull back to nominal
    if (band2_q == flrt_pkg::BandInRange) begin
      target_d = {1'b0, nom2_q};
    end
  end

  logic [24:0]       target3_q;
  logic              fast3_q;
  logic [23:0]       nom3_q;
  logic              rst3_q;
  flrt_pkg::band_e   band3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      target3_q <= target_d;
      fast3_q   <= fast_d;
      nom3_q    <= nom2_q;
      rst3_q    <= rst2_q;
      band3_q   <= band2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: first-order smoothing of the kept ratio.
  //   old*(1-L) + t*L  ==  old + (t - old)*L   (Q0.16, round half up)
  // The kept ratio register is the output ratio register.
  // ---------------------------------------------------------------------
  logic [23:0]                      kept_q, kept_d;
  flrt_pkg::band_e                  band_q;
  logic [flrt_pkg::LambdaW-1:0]     lam;
  logic signed [25:0]               step_diff;
  logic signed [39:0]               step_prod;
  logic signed [41:0]               acc;
  logic [25:0]                      blend_raw;

  always_comb begin
    lam       = fast3_q ? flrt_pkg::LambdaFast : flrt_pkg::LambdaSlow;
    step_diff = $signed({1'b0, target3_q}) - $signed({2'b00, kept_q});
    step_prod = step_diff * $signed({1'b0, lam});
    acc       = $signed({2'b00, kept_q, 16'h0000}) + 42'(step_prod) + 42'sd32768;
    blend_raw = acc[41:16];
    if (rst3_q) begin
      kept_d = nom3_q;
    end else if (blend_raw > 26'(flrt_pkg::RatioMax)) begin
      kept_d = flrt_pkg::RatioMax;
    end else begin
      kept_d = blend_raw[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
      band_q <= flrt_pkg::BandInRange;
    end else if (en_o && v3_q) begin
      kept_q <= kept_d;
      band_q <= band3_q;
    end
  end

  assign out_valid_o = vo_q;
  assign ratio_o     = kept_q;
  assign band_o      = band_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Input is only held off when every stage is full and the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while pipeline has room");

  // The kept ratio changes only when an item enters the output stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en_o && v3_q) |=> $stable(kept_q))
    else $error("kept ratio changed without an item");

  // A restart loads the nominal ratio unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_o && v3_q && rst3_q) |=> (ratio_o == $past(nom3_q)))
    else $error("restart did not load nominal ratio");

  // The clamped target stays within a quarter of nominal, plus one LSB of
  // slack below for very small nominal ratios.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ((target3_q <= 25'(nom3_q) + 25'(nom3_q >> 2)) &&
              (target3_q + 25'(nom3_q >> 2) + 25'd1 >= 25'(nom3_q))))
    else $error("target outside clamp bounds");

  // In range, the target is nominal itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && band3_q == flrt_pkg::BandInRange) |-> (target3_q == {1'b0, nom3_q}))
    else $error("in-range target is not nominal");

endmodule
